[rtl/rtil_pkg.sv]
package rtil_pkg;

	localparam int ENTRIES = 8;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int SLOT_W = 4;
	localparam int ADDR_W = 32;
	localparam int LINK_W = 8;
	localparam int LIFE_W = 4;

	localparam logic [LIFE_W-1:0] FRESH_LIFETIME = LIFE_W'(10);
	localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(ENTRIES);

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_LOOKUP = 2'd2
	} action_t;

	typedef struct packed {
		action_t             action;
		logic [ADDR_W-1:0]   dest_addr;
		logic [ADDR_W-1:0]   next_hop_addr;
		logic [LINK_W-1:0]   link_id;
	} req_t;

	typedef struct packed {
		logic                ok;
		logic [SLOT_W-1:0]   slot_index;
	} rsp_t;

endpackage

[rtl/rtil_if.sv]
interface rtil_req_if;
	logic          valid;
	logic          ready;
	rtil_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rtil_rsp_if;
	logic          valid;
	logic          ready;
	rtil_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/route_table_insert_lookup.sv]
// The request is taken only while idle, then the scan visits one slot per cycle
// through a single shared destination comparator; the result is registered.
// Clear and unused codes finish in the first scan step; insert and lookup stop
// at the first free (insert) or matching (lookup) slot, or at the last slot.
// Reset: asynchronous, clears every lifetime (all slots free) and the sequencer;
// stored addresses and link bytes are undefined until written.
module route_table_insert_lookup (
	input  logic        clk,
	input  logic        arst_n,
	rtil_req_if.sink    req,
	rtil_rsp_if.source  rsp
);
	import rtil_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [LIFE_W-1:0]   life_q [ENTRIES];
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	action_t             act_q;
	logic [ADDR_W-1:0]   dest_q;
	logic [ADDR_W-1:0]   hop_q;
	logic [LINK_W-1:0]   link_q;

	logic [ADDR_W-1:0]   dest_mem [ENTRIES];
	logic [ADDR_W-1:0]   hop_mem [ENTRIES];
	logic [LINK_W-1:0]   link_mem [ENTRIES];

	logic [IDX_W-1:0]    idx;
	logic                last;
	logic                live;
	logic                hit;
	logic                out_free;
	logic                fin;
	logic                wr;
	logic                commit;
	rsp_t                res;

	assign idx = cnt_q[IDX_W-1:0];
	assign last = (cnt_q == CNT_W'(ENTRIES - 1));
	assign live = (life_q[idx] != '0);
	assign hit = live && (dest_mem[idx] == dest_q);
	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		fin = 1'b0;
		wr = 1'b0;
		res.ok = 1'b0;
		res.slot_index = '0;
		case (act_q)
			ACT_CLEAR: begin
				fin = 1'b1;
				res.ok = 1'b1;
			end
			ACT_INSERT: begin
				if (!live) begin
					fin = 1'b1;
					wr = 1'b1;
					res.ok = 1'b1;
					res.slot_index = SLOT_W'(cnt_q);
				end else if (last) begin
					fin = 1'b1;
					res.slot_index = SLOT_NONE;
				end
			end
			ACT_LOOKUP: begin
				if (hit) begin
					fin = 1'b1;
					res.ok = 1'b1;
					res.slot_index = SLOT_W'(cnt_q);
				end else if (last) begin
					fin = 1'b1;
					res.slot_index = SLOT_NONE;
				end
			end
			default: begin
				fin = 1'b1;
			end
		endcase
	end

	assign commit = (state_q == S_SCAN) && fin && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				life_q[i] <= '0;
			end
		end else begin
			if (rsp_valid_q && rsp.ready && !commit) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cnt_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (commit) begin
						rsp_valid_q <= 1'b1;
						rsp_q <= res;
						state_q <= S_IDLE;
						if (act_q == ACT_CLEAR) begin
							for (int i = 0; i < ENTRIES; i++) begin
								life_q[i] <= '0;
							end
						end
						if (wr) begin
							life_q[idx] <= FRESH_LIFETIME;
						end
					end else if (!fin) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the accepted request for the scan
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q <= req.data.action;
			dest_q <= req.data.dest_addr;
			hop_q <= req.data.next_hop_addr;
			link_q <= req.data.link_id;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && wr) begin
			dest_mem[idx] <= dest_q;
			hop_mem[idx] <= hop_q;
			link_mem[idx] <= link_q;
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request transfer did not start a scan");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (cnt_q < CNT_W'(ENTRIES)))
		else $error("scan counter ran past the last slot");

	a_insert_live: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && wr) |=> (life_q[$past(idx)] == FRESH_LIFETIME) && rsp.valid
			&& rsp.data.ok)
		else $error("insert did not mark its slot live");

endmodule
